[src/iaql_pkg.sv]
// Shared constants, codes and types for the indexed array list.
package iaql_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W    = 2;
  localparam int IN_IDX_W = 5;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 5;
  localparam int ST_W    = 2;
  localparam int IDX_W   = $clog2(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Action broadcast to every cell in the chain.
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_DELETE = 2'd3
  } act_t;

  typedef struct packed {
    act_t                   act;
    logic [IDX_W-1:0]       pos;
    logic [DATA_WIDTH-1:0]  data;
  } cell_cmd_t;

endpackage

[src/indexed_array_list.sv]
// Top level of the indexed array list: request decode, cell chain, result register.
// Indexed array list of CAPACITY entries held in a chain of cells. Each request
// (get, set, add at index, remove at index) is taken and its word
// appears on the result channel on the next cycle; a new request can be taken
// every cycle. All cells shift at once, so insert and remove take no longer than
// get and set. The single result register sets the rate: input stalls only while
// a finished result waits on a stalled output. Add when full reports full, bad
// positions report out of range, and get/set/remove on an empty list report empty;
// none of these change the list, and every non-ok result carries a zero value.
module indexed_array_list (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [iaql_pkg::OP_W-1:0]      in_operation,
  input  logic [iaql_pkg::IN_IDX_W-1:0]  in_index,
  input  logic [iaql_pkg::VAL_W-1:0]     in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iaql_pkg::VAL_W-1:0]     out_read_value,
  output logic [iaql_pkg::CNT_W-1:0]     out_count,
  output logic [iaql_pkg::ST_W-1:0]      out_status
);
  import iaql_pkg::*;

  logic                  in_accept;
  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] left_q [CAPACITY];
  logic [DATA_WIDTH-1:0] right_q [CAPACITY];

  logic [CNT_W-1:0]      count_r, count_nxt;
  status_t               status_c;
  act_t                  act_c;
  logic [DATA_WIDTH-1:0] rd_c;
  logic [CNT_W-1:0]      idx_c;

  logic                  out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]      out_value_r;
  logic [CNT_W-1:0]      out_count_r;
  status_t               out_status_r;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign idx_c     = CNT_W'(in_index);

  // Request decode against the current count.
  always_comb begin
    status_c  = ST_OK;
    act_c     = ACT_NONE;
    count_nxt = count_r;
    rd_c      = '0;
    if (op_t'(in_operation) == OP_ADD) begin
      if (count_r >= CNT_W'(CAPACITY)) begin
        status_c = ST_FULL;
      end else if (idx_c > count_r) begin
        status_c = ST_RANGE;
      end else begin
        act_c     = ACT_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (count_r == '0) begin
      status_c = ST_EMPTY;
    end else if (idx_c >= count_r) begin
      status_c = ST_RANGE;
    end else begin
      rd_c = cell_q[in_index[IDX_W-1:0]];
      case (op_t'(in_operation))
        OP_SET: act_c = ACT_WRITE;
        OP_REMOVE: begin
          act_c     = ACT_DELETE;
          count_nxt = count_r - CNT_W'(1);
        end
        default: act_c = ACT_NONE;
      endcase
    end
  end

  assign cmd.act  = in_accept ? act_c : ACT_NONE;
  assign cmd.pos  = in_index[IDX_W-1:0];
  assign cmd.data = DATA_WIDTH'(in_value);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_q[g] = '0;
      end else begin : g_mid_l
        assign left_q[g] = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_q[g] = '0;
      end else begin : g_mid_r
        assign right_q[g] = cell_q[g+1];
      end
      iaql_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .cell_pos (IDX_W'(g)),
        .left_q   (left_q[g]),
        .right_q  (right_q[g]),
        .q        (cell_q[g])
      );
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) count_r <= count_nxt;
    end
  end

  // Result word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_value_r  <= VAL_W'(rd_c);
      out_count_r  <= count_nxt;
      out_status_r <= status_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && act_c == ACT_INSERT) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("failed request returned data");

endmodule

[src/iaql_cell.sv]
// One list position: holds an entry and shifts to or from its neighbors.
module iaql_cell (
  input  logic                           clk,
  input  iaql_pkg::cell_cmd_t            cmd,
  input  logic [iaql_pkg::IDX_W-1:0]     cell_pos,
  input  logic [iaql_pkg::DATA_WIDTH-1:0] left_q,
  input  logic [iaql_pkg::DATA_WIDTH-1:0] right_q,
  output logic [iaql_pkg::DATA_WIDTH-1:0] q
);
  import iaql_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.act)
      ACT_WRITE: begin
        if (cell_pos == cmd.pos) data_nxt = cmd.data;
      end
      ACT_INSERT: begin
        if (cell_pos == cmd.pos) data_nxt = cmd.data;
        else if (cell_pos > cmd.pos) data_nxt = left_q;
      end
      ACT_DELETE: begin
        if (cell_pos >= cmd.pos) data_nxt = right_q;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
